>>> rtl/memory_change_watch_filter_defines.svh
// assertion macros for the memory change watch filter
// used by memory_change_watch_filter.sv, depends on nothing else
`ifndef MEMORY_CHANGE_WATCH_FILTER_DEFINES_SVH
`define MEMORY_CHANGE_WATCH_FILTER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MCWF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MCWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mcwf_pkg.sv
// types and constants of the memory change watch filter
// no dependencies; used by memory_change_watch_filter.sv
`default_nettype none

package mcwf_pkg;

	// number of watched entries and the memory index width
	localparam int WATCH_DEPTH = 64;
	localparam int IDX_W       = (WATCH_DEPTH > 1) ? $clog2(WATCH_DEPTH) : 1;

	// change count saturation and byte spacing of entries
	localparam logic [19:0] SAT_LIMIT  = 20'd1000000;
	localparam int          WORD_SHIFT = 2;

	// reset values of the configuration registers
	localparam logic [31:0] START_ADDRESS_RST = 32'hC022_0000;
	localparam logic [19:0] COUNT_LOW_RST     = 20'd1;
	localparam logic [19:0] COUNT_HIGH_RST    = 20'd5;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_START_ADDRESS = 3'd0,
		REG_BOOL_ONLY     = 3'd1,
		REG_VALUE_LOW     = 3'd2,
		REG_VALUE_HIGH    = 3'd3,
		REG_COUNT_LOW     = 3'd4,
		REG_COUNT_HIGH    = 3'd5,
		REG_RATE_LOW      = 3'd6,
		REG_RATE_HIGH     = 3'd7
	} cfg_reg_t;

	// sample commands
	typedef enum logic {
		CMD_BASELINE = 1'b0,
		CMD_UPDATE   = 1'b1
	} cmd_t;

	typedef logic [IDX_W-1:0] idx_t;

	// one memory word: mirror, saturated change count, logged mark
	typedef struct packed {
		logic [31:0] mirror;
		logic [19:0] count;
		logic        logged;
	} entry_t;

endpackage

`default_nettype wire

>>> rtl/memory_change_watch_filter.sv
// memory change watch filter top level: entry memory, update pipeline, filters
// depends on mcwf_pkg.sv and memory_change_watch_filter_defines.svh
`default_nettype none

// Takes one sample per clock: busy stays low, so a sample is taken at every
// edge with start high. Each sample reads its entry from an entry memory with
// one read port and one write port (registered read), is compared,
// counted and filtered in the next cycle and written back at the end of that
// cycle; a following sample to the same entry gets the fresh word through a
// forwarding register. A report shows on the result ports with done high for
// one cycle, the cycle after the compare cycle, and must be taken then: the
// receiver cannot hold it off.
// Baseline commands, filtered samples and entries already logged give no beat.
// The rate filter is evaluated by cross-multiplying the limits with the
// elapsed time, so no divider is needed. Entries are undefined until their
// first baseline.
`include "memory_change_watch_filter_defines.svh"

module memory_change_watch_filter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write port
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	// sample command
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               command,
	input  wire logic [5:0]         entry_index,
	input  wire logic signed [31:0] sample_value,
	input  wire logic [31:0]        elapsed_seconds,
	// report
	output logic                    done,
	output logic [31:0]             word_address,
	output logic [19:0]             change_count,
	output logic signed [31:0]      current_value
);

	// configuration registers
	logic [31:0]        start_address_q;
	logic               bool_only_q;
	logic signed [31:0] value_low_q;
	logic signed [31:0] value_high_q;
	logic [19:0]        count_low_q;
	logic [19:0]        count_high_q;
	logic [19:0]        rate_low_q;
	logic [19:0]        rate_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_address_q <= mcwf_pkg::START_ADDRESS_RST;
			bool_only_q     <= 1'b0;
			value_low_q     <= '0;
			value_high_q    <= '0;
			count_low_q     <= mcwf_pkg::COUNT_LOW_RST;
			count_high_q    <= mcwf_pkg::COUNT_HIGH_RST;
			rate_low_q      <= '0;
			rate_high_q     <= '0;
		end else if (cfg_write) begin
			case (mcwf_pkg::cfg_reg_t'(cfg_index))
				mcwf_pkg::REG_START_ADDRESS: start_address_q <= cfg_data;
				mcwf_pkg::REG_BOOL_ONLY:     bool_only_q     <= cfg_data[0];
				mcwf_pkg::REG_VALUE_LOW:     value_low_q     <= cfg_data;
				mcwf_pkg::REG_VALUE_HIGH:    value_high_q    <= cfg_data;
				mcwf_pkg::REG_COUNT_LOW:     count_low_q     <= cfg_data[19:0];
				mcwf_pkg::REG_COUNT_HIGH:    count_high_q    <= cfg_data[19:0];
				mcwf_pkg::REG_RATE_LOW:      rate_low_q      <= cfg_data[19:0];
				mcwf_pkg::REG_RATE_HIGH:     rate_high_q     <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// accept side
	logic           accept;
	logic           in_range;
	mcwf_pkg::idx_t rd_idx;
	logic [20:0]    rate_high_inc;
	logic [51:0]    low_prod;
	logic [52:0]    high_prod;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign in_range = (32'(entry_index) < 32'(mcwf_pkg::WATCH_DEPTH));
	assign rd_idx   = mcwf_pkg::idx_t'(entry_index);

	// rate limits times elapsed time: floor(c/e) < L iff c < L*e,
	// floor(c/e) > H iff c >= (H+1)*e
	assign rate_high_inc = {1'b0, rate_high_q} + 21'd1;
	assign low_prod      = {32'd0, rate_low_q} * {20'd0, elapsed_seconds};
	assign high_prod     = {32'd0, rate_high_inc} * {21'd0, elapsed_seconds};

	// stage 1 pipeline registers
	logic               v_s1;
	logic               cmd_s1;
	mcwf_pkg::idx_t     idx_s1;
	logic signed [31:0] val_s1;
	logic               ezero_s1;
	logic [51:0]        low_prod_s1;
	logic [52:0]        high_prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1       <= command;
			idx_s1       <= rd_idx;
			val_s1       <= sample_value;
			ezero_s1     <= (elapsed_seconds == 32'd0);
			low_prod_s1  <= low_prod;
			high_prod_s1 <= high_prod;
		end
	end

	// entry memory, registered read
	mcwf_pkg::entry_t mem [mcwf_pkg::WATCH_DEPTH];
	mcwf_pkg::entry_t rd_q;
	logic             wr_en;
	mcwf_pkg::entry_t wr_data;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= mem[rd_idx];
		end
		if (wr_en) begin
			mem[idx_s1] <= wr_data;
		end
	end

	// forwarding of the word written at the edge this read was taken
	logic             fwd_valid_q;
	mcwf_pkg::idx_t   fwd_idx_q;
	mcwf_pkg::entry_t fwd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= wr_data;
		end
	end

	// stage 1 update and filters
	mcwf_pkg::entry_t cur;
	logic             changed;
	logic [19:0]      new_count;
	logic             new_logged;
	logic             pass;
	logic             report_s1;

	always_comb begin
		cur = (fwd_valid_q && (fwd_idx_q == idx_s1)) ? fwd_data_q : rd_q;

		changed   = (cur.mirror != val_s1);
		new_count = cur.count;
		if (changed && (cur.count < mcwf_pkg::SAT_LIMIT)) begin
			new_count = cur.count + 20'd1;
		end
		new_logged = changed ? 1'b0 : cur.logged;

		pass = 1'b1;
		if (bool_only_q && (val_s1 != 32'sd0) && (val_s1 != 32'sd1) && (val_s1 != -32'sd1)) begin
			pass = 1'b0;
		end
		if ((value_low_q != 32'sd0) && (val_s1 < value_low_q)) begin
			pass = 1'b0;
		end
		if ((value_high_q != 32'sd0) && (val_s1 > value_high_q)) begin
			pass = 1'b0;
		end
		if ((count_low_q != 20'd0) && (new_count < count_low_q)) begin
			pass = 1'b0;
		end
		if ((count_high_q != 20'd0) && (new_count > count_high_q)) begin
			pass = 1'b0;
		end
		// zero elapsed time stands for the saturated rate
		if (rate_low_q != 20'd0) begin
			if (ezero_s1 ? (mcwf_pkg::SAT_LIMIT < rate_low_q)
				: ({32'd0, new_count} < low_prod_s1)) begin
				pass = 1'b0;
			end
		end
		if (rate_high_q != 20'd0) begin
			if (ezero_s1 ? (mcwf_pkg::SAT_LIMIT > rate_high_q)
				: ({33'd0, new_count} >= high_prod_s1)) begin
				pass = 1'b0;
			end
		end

		report_s1 = 1'b0;
		wr_en     = v_s1;
		if (mcwf_pkg::cmd_t'(cmd_s1) == mcwf_pkg::CMD_BASELINE) begin
			wr_data = '{mirror: val_s1, count: 20'd0, logged: 1'b0};
		end else begin
			report_s1 = v_s1 && pass && !new_logged;
			wr_data   = '{mirror: val_s1, count: new_count,
				logged: new_logged || (pass && !new_logged)};
		end
	end

	// report registers
	logic               done_q;
	logic [31:0]        word_address_q;
	logic [19:0]        change_count_q;
	logic signed [31:0] current_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= report_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (report_s1) begin
			word_address_q  <= start_address_q + (32'(idx_s1) << mcwf_pkg::WORD_SHIFT);
			change_count_q  <= new_count;
			current_value_q <= val_s1;
		end
	end

	assign done          = done_q;
	assign word_address  = word_address_q;
	assign change_count  = change_count_q;
	assign current_value = current_value_q;

	// checks
	`MCWF_ASSERT_NOW(a_done_from_update, clk, arst_n, done_q,
		$past(v_s1) && ($past(cmd_s1) == mcwf_pkg::CMD_UPDATE),
		"report beat without an update in the previous cycle")
	`MCWF_ASSERT_NEXT(a_report_marks_logged, clk, arst_n, report_s1,
		fwd_valid_q && fwd_data_q.logged,
		"reported entry not written back as logged")
	`MCWF_ASSERT_NOW(a_count_saturates, clk, arst_n, wr_en,
		wr_data.count <= mcwf_pkg::SAT_LIMIT,
		"change count beyond saturation limit")

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for memory_change_watch_filter: predicts each change report
// from its own copy of the entry state and filter registers and checks every beat
// depends on mcwf_pkg.sv and the block's RTL only
module tb;
	import mcwf_pkg::*;

	localparam logic [31:0] ZERO_TIME_RATE = 32'd1000000;
	localparam logic [31:0] ENTRY_BYTES    = 32'd4;
	localparam int          SETTLE_CYCLES  = 4;
	localparam int          DRAIN_LIMIT    = 1000;
	localparam int          PHASE_ITEMS    = 100;

	typedef struct packed {
		logic [31:0] addr;
		logic [19:0] count;
		logic [31:0] value;
	} report_t;

	// predicted entry state, filter settings and reports still owed by the block
	class change_report_predictor;
		logic [31:0]        base_addr;
		logic               bool_only;
		logic signed [31:0] value_low;
		logic signed [31:0] value_high;
		logic [19:0]        count_low;
		logic [19:0]        count_high;
		logic [19:0]        rate_low;
		logic [19:0]        rate_high;
		logic [31:0]        mirror [WATCH_DEPTH];
		logic [19:0]        changes [WATCH_DEPTH];
		logic               logged [WATCH_DEPTH];
		report_t            reports_due [$];
		int                 errors;

		function new();
			base_addr  = START_ADDRESS_RST;
			bool_only  = 1'b0;
			value_low  = '0;
			value_high = '0;
			count_low  = COUNT_LOW_RST;
			count_high = COUNT_HIGH_RST;
			rate_low   = '0;
			rate_high  = '0;
			errors     = 0;
			foreach (mirror[i]) begin
				mirror[i]  = '0;
				changes[i] = '0;
				logged[i]  = 1'b0;
			end
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void write_reg(cfg_reg_t r, logic [31:0] d);
			case (r)
			REG_START_ADDRESS: base_addr = d;
			REG_BOOL_ONLY:     bool_only = d[0];
			REG_VALUE_LOW:     value_low = d;
			REG_VALUE_HIGH:    value_high = d;
			REG_COUNT_LOW:     count_low = d[19:0];
			REG_COUNT_HIGH:    count_high = d[19:0];
			REG_RATE_LOW:      rate_low = d[19:0];
			REG_RATE_HIGH:     rate_high = d[19:0];
			default:           ;
			endcase
		endfunction

		// every enabled filter must pass; a zero limit switches its filter off
		function bit passes(logic signed [31:0] v, logic [19:0] c, logic [31:0] el);
			logic [31:0] rate;
			if (bool_only && v != 0 && v != 1 && v != -1)
				return 1'b0;
			if (value_low != 0 && v < value_low)
				return 1'b0;
			if (value_high != 0 && v > value_high)
				return 1'b0;
			if (count_low != 0 && c < count_low)
				return 1'b0;
			if (count_high != 0 && c > count_high)
				return 1'b0;
			rate = (el == 0) ? ZERO_TIME_RATE : {12'd0, c} / el;
			if (rate_low != 0 && rate < {12'd0, rate_low})
				return 1'b0;
			if (rate_high != 0 && rate > {12'd0, rate_high})
				return 1'b0;
			return 1'b1;
		endfunction

		// one accepted sample: update the entry and queue the report it causes
		function void apply_sample(cmd_t cmd, idx_t idx, logic signed [31:0] v,
				logic [31:0] el);
			report_t r;
			if (cmd == CMD_BASELINE) begin
				mirror[idx]  = v;
				changes[idx] = '0;
				logged[idx]  = 1'b0;
				return;
			end
			if (mirror[idx] != v) begin
				mirror[idx] = v;
				if (changes[idx] < SAT_LIMIT)
					changes[idx] = changes[idx] + 20'd1;
				logged[idx] = 1'b0;
			end
			if (!passes(v, changes[idx], el) || logged[idx])
				return;
			logged[idx] = 1'b1;
			r.addr  = base_addr + ENTRY_BYTES * {26'd0, idx};
			r.count = changes[idx];
			r.value = v;
			reports_due.push_back(r);
		endfunction

		function void check_report(logic [31:0] a, logic [19:0] c, logic [31:0] v);
			report_t want;
			if (reports_due.size() == 0) begin
				flag($sformatf("unexpected report addr %h count %0d value %h", a, c, v));
				return;
			end
			want = reports_due.pop_front();
			if (want.addr !== a || want.count !== c || want.value !== v)
				flag($sformatf("expected addr %h count %0d value %h, got addr %h count %0d value %h",
					want.addr, want.count, want.value, a, c, v));
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_write = 1'b0;
	logic [2:0]          cfg_index = '0;
	logic [31:0]         cfg_data = '0;
	logic                start = 1'b0;
	logic                busy;
	logic                command = 1'b0;
	logic [5:0]          entry_index = '0;
	logic signed [31:0]  sample_value = '0;
	logic [31:0]         elapsed_seconds = '0;
	logic                done;
	logic [31:0]         word_address;
	logic [19:0]         change_count;
	logic signed [31:0]  current_value;

	change_report_predictor sb;
	bit                     based [WATCH_DEPTH];
	logic [31:0]            phase_regs [8];

	memory_change_watch_filter DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.entry_index     (entry_index),
		.sample_value    (sample_value),
		.elapsed_seconds (elapsed_seconds),
		.done            (done),
		.word_address    (word_address),
		.change_count    (change_count),
		.current_value   (current_value)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// report beats cannot be held off: take each one at the edge ending its cycle
	always @(posedge clk)
		if (arst_n && done === 1'b1)
			sb.check_report(word_address, change_count, current_value);

	// present one sample and hold it until the edge that takes it
	task automatic send_sample(cmd_t cmd, idx_t idx, logic [31:0] v, logic [31:0] el);
		start           <= 1'b1;
		command         <= cmd;
		entry_index     <= idx;
		sample_value    <= v;
		elapsed_seconds <= el;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		if (cmd == CMD_BASELINE)
			based[idx] = 1'b1;
		sb.apply_sample(cmd, idx, v, el);
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// hold off until every owed report is in, then let the pipeline settle
	task automatic wait_quiet();
		int n;
		n = 0;
		start <= 1'b0;
		while (sb.reports_due.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all eight configuration registers from phase_regs
	task automatic configure();
		for (int i = 0; i < 8; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data  <= phase_regs[i];
			@(posedge clk);
			sb.write_reg(cfg_reg_t'(i), phase_regs[i]);
		end
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_settings();
		phase_regs[REG_START_ADDRESS] = $urandom;
		phase_regs[REG_BOOL_ONLY]     = $urandom_range(0, 1);
		case ($urandom_range(0, 2))
		0:       phase_regs[REG_VALUE_LOW] = '0;
		1:       phase_regs[REG_VALUE_LOW] = -$urandom_range(1, 3);
		default: phase_regs[REG_VALUE_LOW] = $urandom;
		endcase
		case ($urandom_range(0, 2))
		0:       phase_regs[REG_VALUE_HIGH] = '0;
		1:       phase_regs[REG_VALUE_HIGH] = $urandom_range(1, 3);
		default: phase_regs[REG_VALUE_HIGH] = $urandom;
		endcase
		phase_regs[REG_COUNT_LOW] = $urandom_range(0, 2);
		case ($urandom_range(0, 2))
		0:       phase_regs[REG_COUNT_HIGH] = '0;
		1:       phase_regs[REG_COUNT_HIGH] = $urandom_range(2, 20);
		default: phase_regs[REG_COUNT_HIGH] = 32'd1000000;
		endcase
		phase_regs[REG_RATE_LOW]  = $urandom_range(0, 1);
		phase_regs[REG_RATE_HIGH] = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom_range(1, 3);
	endtask

	// mostly baseline-then-update traffic on a few hot entries, some on any entry
	task automatic random_sample(bit idle);
		cmd_t        cmd;
		idx_t        idx;
		logic [31:0] v;
		logic [31:0] el;
		idx = ($urandom_range(0, 9) < 7) ? idx_t'($urandom_range(0, 5)) : idx_t'($urandom);
		cmd = ($urandom_range(0, 9) == 0) ? CMD_BASELINE : CMD_UPDATE;
		// an entry is only updated once it holds a baseline
		if (!based[idx])
			cmd = CMD_BASELINE;
		case ($urandom_range(0, 11))
		0, 1, 2, 3: v = $urandom_range(0, 4) - 2;
		4, 5:       v = $urandom;
		6:          v = 32'h8000_0000;
		7:          v = 32'h7FFF_FFFF;
		default:    v = sb.mirror[idx];
		endcase
		case ($urandom_range(0, 19))
		0, 1:               el = '0;
		12, 13, 14, 15, 16: el = $urandom_range(4, 100);
		17, 18:             el = $urandom;
		19:                 el = 32'hFFFF_FFFF;
		default:            el = $urandom_range(1, 3);
		endcase
		send_sample(cmd, idx, v, el);
		if (idle && $urandom_range(0, 4) == 0)
			pause($urandom_range(1, 12));
	endtask

	// stimulus
	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats under reset settings: no change, first change, zero time,
		// already logged, sign extremes, count past the upper limit, re-baseline
		send_sample(CMD_BASELINE, 6'd0, 32'd0, 32'd0);
		send_sample(CMD_UPDATE, 6'd0, 32'd0, 32'd5);
		send_sample(CMD_UPDATE, 6'd0, 32'd1, 32'd0);
		send_sample(CMD_UPDATE, 6'd0, 32'd1, 32'd1);
		send_sample(CMD_UPDATE, 6'd0, 32'hFFFF_FFFF, 32'd1);
		send_sample(CMD_BASELINE, 6'd63, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_sample(CMD_UPDATE, 6'd63, 32'h8000_0000, 32'hFFFF_FFFF);
		send_sample(CMD_UPDATE, 6'd63, 32'h7FFF_FFFF, 32'd0);
		send_sample(CMD_BASELINE, 6'd42, 32'hAAAA_AAAA, 32'd0);
		send_sample(CMD_BASELINE, 6'd21, 32'h5555_5555, 32'd0);
		for (int i = 1; i <= 7; i++)
			send_sample(CMD_UPDATE, 6'd21, i, i);
		send_sample(CMD_UPDATE, 6'd42, 32'h5555_5555, 32'd2);
		send_sample(CMD_UPDATE, 6'd42, 32'h5555_5555, 32'd2);
		send_sample(CMD_BASELINE, 6'd0, 32'd5, 32'd0);
		send_sample(CMD_UPDATE, 6'd0, 32'd5, 32'd0);

		// all filters off, address wraps past the top
		wait_quiet();
		phase_regs = '{32'hFFFF_FFFC, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
		configure();
		repeat (PHASE_ITEMS) random_sample(1'b1);

		// boolean values only, every range filter at its widest nonzero setting
		wait_quiet();
		phase_regs = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1000000,
			32'd1, 32'd1000000};
		configure();
		repeat (PHASE_ITEMS) random_sample(1'b1);

		// extreme value limits, tight rate ceiling
		wait_quiet();
		phase_regs = '{32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd2,
			32'd1000000, 32'd0, 32'd1};
		configure();
		repeat (PHASE_ITEMS) random_sample(1'b1);

		// random settings, the last stretch at full rate
		wait_quiet();
		random_settings();
		configure();
		repeat (PHASE_ITEMS) random_sample(1'b1);
		wait_quiet();
		random_settings();
		configure();
		repeat (PHASE_ITEMS) random_sample(1'b0);

		wait_quiet();
		if (sb.reports_due.size() != 0)
			sb.flag($sformatf("%0d reports never arrived", sb.reports_due.size()));
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
